// File: design/sqltn_pkg.sv
package sqltn_pkg;

	localparam int KW_N = 5;

	typedef logic [KW_N-1:0] kw_mask_t;
	typedef logic [2:0]      name_pos_t;

	// Type codes reported in a result word.
	localparam logic [1:0] TYPE_NONE = 2'd0;
	localparam logic [1:0] TYPE_INT  = 2'd1;
	localparam logic [1:0] TYPE_REAL = 2'd2;
	localparam logic [1:0] TYPE_TEXT = 2'd3;

	// Status codes; a nonzero code is also the latched error.
	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_SIZE   = 2'd1;
	localparam logic [1:0] STAT_FORMAT = 2'd2;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_Z  = 8'h7a;
	localparam logic [7:0] CASE_BIT  = 8'h20;

	localparam name_pos_t POS_MAX = 3'd7;

	// Keywords, left justified: character p sits at bits [63-8p -: 8].
	// Order: int, integer, real, text, varchar.
	localparam logic [63:0] KW_TEXT [KW_N] = '{
		{"int",     40'h0},
		{"integer",  8'h0},
		{"real",    32'h0},
		{"text",    32'h0},
		{"varchar",  8'h0}
	};
	localparam name_pos_t  KW_LEN  [KW_N] = '{3'd3, 3'd7, 3'd4, 3'd4, 3'd7};
	localparam logic [1:0] KW_TYPE [KW_N] = '{TYPE_INT, TYPE_INT, TYPE_REAL,
		TYPE_TEXT, TYPE_TEXT};

	typedef struct packed {
		logic [7:0] ch;
		logic       is_terminator;
	} item_t;

	typedef struct packed {
		logic [1:0]  type_code;
		logic [31:0] size_plus_one;
		logic [1:0]  status;
	} res_t;

	// Keyword matcher outputs: mask after one more letter, and the mask
	// of keywords whose length equals the name length so far.
	typedef struct packed {
		kw_mask_t step_mask;
		kw_mask_t close_mask;
	} kw_t;

	// Type of the first keyword left in the mask.
	function automatic logic [1:0] type_of_mask(input kw_mask_t m);
		logic [1:0] t;
		t = TYPE_NONE;
		for (int k = KW_N - 1; k >= 0; k--) begin
			if (m[k]) begin
				t = KW_TYPE[k];
			end
		end
		return t;
	endfunction

endpackage

// File: design/sqltn_if.sv
interface sqltn_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       is_terminator;

	modport source(output valid, output ch, output is_terminator, input ready);
	modport sink(input valid, input ch, input is_terminator, output ready);
endinterface

interface sqltn_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  type_code;
	logic [31:0] size_plus_one;
	logic [1:0]  status;

	modport source(output valid, output type_code, output size_plus_one,
		output status, input ready);
	modport sink(input valid, input type_code, input size_plus_one,
		input status, output ready);
endinterface

// File: design/sqltn_kw.sv
module sqltn_kw (
	input  sqltn_pkg::kw_mask_t  mask,
	input  sqltn_pkg::name_pos_t pos,
	input  logic [7:0]           lc,
	output sqltn_pkg::kw_t       kw
);
	import sqltn_pkg::*;

	// Compare the lowered character against each keyword at the current
	// position; the position never reaches past a keyword that still matches.
	always_comb begin
		for (int k = 0; k < KW_N; k++) begin
			kw.step_mask[k] = mask[k] && (pos < KW_LEN[k])
				&& (KW_TEXT[k][{POS_MAX - pos, 3'b000} +: 8] == lc);
			kw.close_mask[k] = mask[k] && (pos == KW_LEN[k]);
		end
	end

endmodule

// File: design/sqltn_fsm.sv
module sqltn_fsm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  sqltn_pkg::item_t  item,
	output sqltn_pkg::res_t   res
);
	import sqltn_pkg::*;

	typedef enum logic [2:0] {
		PH_LEAD,
		PH_NAME,
		PH_AFTER,
		PH_SIZE,
		PH_TAIL,
		PH_SKIP
	} phase_t;

	phase_t      phase_q, phase_d, close_phase, phase_w;
	name_pos_t   pos_q, pos_d;
	kw_mask_t    mask_q, mask_d, mask_w;
	logic [31:0] acc_q, acc_d, acc_x10;
	logic        seen_q, seen_d;
	logic [1:0]  err_q, err_d;
	logic [7:0]  lc;
	logic        is_letter, in_name;
	kw_t         kw;

	assign lc        = item.ch | CASE_BIT;
	assign is_letter = lc inside {[CH_LOW_A:CH_LOW_Z]};
	assign in_name   = (phase_q == PH_LEAD) || (phase_q == PH_NAME);
	assign acc_x10   = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0}
		+ {28'd0, item.ch[3:0]};

	sqltn_kw u_kw (
		.mask (mask_q),
		.pos  (pos_q),
		.lc   (lc),
		.kw   (kw)
	);

	assign close_phase = (kw.close_mask != '0) ? PH_AFTER : PH_SKIP;

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		mask_d  = mask_q;
		acc_d   = acc_q;
		seen_d  = seen_q;
		err_d   = err_q;
		phase_w = in_name ? close_phase : phase_q;
		mask_w  = in_name ? kw.close_mask : mask_q;
		res     = '0;

		if (item.is_terminator) begin
			// A name still open is closed first; leading-space phase closes
			// to the empty name, which reports as unknown.
			if (err_q != STAT_OK) begin
				res.status = err_q;
			end else if (phase_w == PH_SIZE) begin
				res.status = STAT_SIZE;
			end else if (phase_w == PH_AFTER || phase_w == PH_TAIL) begin
				res.type_code     = type_of_mask(mask_w);
				res.size_plus_one = seen_q ? acc_q + 32'd1 : 32'd0;
			end
			phase_d = PH_LEAD;
			pos_d   = '0;
			mask_d  = '1;
			acc_d   = '0;
			seen_d  = 1'b0;
			err_d   = STAT_OK;
		end else if (err_q == STAT_OK) begin
			if (phase_q == PH_LEAD && item.ch == CH_SPACE) begin
				phase_d = PH_LEAD;
			end else if (in_name && is_letter) begin
				phase_d = PH_NAME;
				mask_d  = kw.step_mask;
				pos_d   = (pos_q == POS_MAX) ? POS_MAX : pos_q + 3'd1;
			end else begin
				// The character that ends a name is handled by the phase
				// that the name leads into.
				phase_d = phase_w;
				mask_d  = mask_w;
				case (phase_w)
					PH_AFTER: begin
						if (item.ch == CH_LPAREN) begin
							phase_d = PH_SIZE;
						end else if (item.ch != CH_SPACE) begin
							err_d = STAT_FORMAT;
						end
					end
					PH_SIZE: begin
						if (item.ch == CH_RPAREN) begin
							seen_d  = 1'b1;
							phase_d = PH_TAIL;
						end else if (item.ch inside {[CH_ZERO:CH_NINE]}) begin
							acc_d = acc_x10;
						end else if (item.ch != CH_SPACE) begin
							err_d = STAT_SIZE;
						end
					end
					PH_TAIL: begin
						if (item.ch != CH_SPACE) begin
							err_d = STAT_FORMAT;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			pos_q   <= '0;
			mask_q  <= '1;
			acc_q   <= '0;
			seen_q  <= 1'b0;
			err_q   <= STAT_OK;
		end else if (fire) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			mask_q  <= mask_d;
			acc_q   <= acc_d;
			seen_q  <= seen_d;
			err_q   <= err_d;
		end
	end

endmodule

// File: design/sql_type_name_parser.sv
// Channel  Dir  Fields                                Word
// chars    in   ch[7:0], is_terminator                 one character or end mark
// result   out  type_code[1:0], size_plus_one[31:0],   one per end mark
//               status[1:0]
//
// A word is taken into an input register and worked on from there: one
// character per cycle while no end mark waits there, set by the parser state
// loop (keyword match, size multiply-add by ten and phase update together).
// An end mark passes the input register, then the output register, which
// holds its result word. Reset clears the parser state and both valid
// flags. A stalled result holds only end marks back; characters keep
// flowing until an end mark meets a full output register.
module sql_type_name_parser (
	input logic    clk,
	input logic    arst_n,
	sqltn_char_if.sink   chars,
	sqltn_res_if.source  result
);
	import sqltn_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	logic  out_free, fire;
	res_t  res;
	res_t  res_q;
	logic  out_valid_q;

	// The output register is free when empty or being drained this cycle.
	assign out_free = !out_valid_q || result.ready;

	// Characters never wait; an end mark waits for room in the output.
	assign fire        = valid_s1 && (!item_s1.is_terminator || out_free);
	assign chars.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			item_s1.ch            <= chars.ch;
			item_s1.is_terminator <= chars.is_terminator;
		end
	end

	sqltn_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && item_s1.is_terminator) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && item_s1.is_terminator) begin
			res_q <= res;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.type_code     = res_q.type_code;
	assign result.size_plus_one = res_q.size_plus_one;
	assign result.status        = res_q.status;

endmodule
